@@ rtl/core/mhpq_pkg.sv @@
package mhpq_pkg;

   // Field widths fixed by the interface.
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 8;

   // Default number of stored values.
   localparam int DEFAULT_CAPACITY = 128;

   // Operation codes.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Status codes.
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Value returned by a remove from an empty queue.
   localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

   typedef struct packed {
      logic                      operation;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] removed_value;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

   // Command broadcast from the controller to every cell of the row.
   typedef struct packed {
      logic                      insert_en;
      logic                      remove_en;
      logic signed [VALUE_W-1:0] new_value;
   } cell_ctrl_type;

endpackage

@@ rtl/core/mhpq_cell.sv @@
module mhpq_cell
   import mhpq_pkg::*;
(
   input  logic                      clock,
   input  cell_ctrl_type             ctrl,
   input  logic                      occupied,
   input  logic                      at_tail,
   input  logic signed [VALUE_W-1:0] left_value,
   input  logic                      left_gt,
   input  logic signed [VALUE_W-1:0] right_value,
   output logic signed [VALUE_W-1:0] value,
   output logic                      gt
);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   // The new value beats this cell's entry; ties keep the stored entry ahead.
   assign gt = occupied && (ctrl.new_value > value_ff);

   // On insert the cells from the insertion point to the tail shift one place
   // toward the tail; the first of them takes the new value. On remove every
   // cell takes its right neighbor's entry.
   always_comb begin
      value_in = value_ff;
      if (ctrl.insert_en && (gt || at_tail)) begin
         value_in = left_gt ? left_value : ctrl.new_value;
      end else if (ctrl.remove_en) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ rtl/core/max_heap_priority_queue.sv @@
// Bounded max priority queue, kept as a sorted row of compare-and-shift cells.
// The result strobe rises in the cycle after the start transfer.
// Throughput: one item per cycle; busy stays low, since each cell finishes
// its compare and shift with its neighbors within the cycle of the transfer.
// Reset: synchronous, active high; it empties the queue and clears the strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.
module max_heap_priority_queue
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_strobe_ff;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;
   cell_ctrl_type             ctrl;
   logic                      is_full;
   logic                      is_empty;
   logic [CNT_W+COUNT_W-1:0]  count_wide;

   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic                      cell_gt    [CAPACITY];

   // Every transfer completes in its own cycle.
   assign busy = 1'b0;

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // Command for the cell row.
   always_comb begin
      ctrl.new_value = req_data.value;
      ctrl.insert_en = start && (req_data.operation == OP_INSERT) && !is_full;
      ctrl.remove_en = start && (req_data.operation == OP_REMOVE) && !is_empty;
   end

   // New count and the result of this transfer.
   always_comb begin
      count_in = count_ff;
      if (ctrl.insert_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.remove_en) begin
         count_in = count_ff - CNT_W'(1);
      end
      count_wide = {{COUNT_W{1'b0}}, count_in};

      rsp_in.count         = count_wide[COUNT_W-1:0];
      rsp_in.status        = STATUS_DONE;
      rsp_in.removed_value = '0;
      unique case (req_data.operation)
         OP_INSERT: begin
            if (is_full) begin
               rsp_in.status = STATUS_FULL;
            end
         end
         OP_REMOVE: begin
            if (is_empty) begin
               rsp_in.status        = STATUS_EMPTY;
               rsp_in.removed_value = EMPTY_VALUE;
            end else begin
               rsp_in.removed_value = cell_value[0];
            end
         end
         default: begin
            rsp_in.status = STATUS_DONE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= start;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (start) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Row of cells, largest value in cell zero.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_value;
      logic                      left_gt;
      logic signed [VALUE_W-1:0] right_value;

      if (i == 0) begin : g_head
         assign left_value = req_data.value;
         assign left_gt    = 1'b0;
      end else begin : g_body
         assign left_value = cell_value[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      mhpq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (CNT_W'(i) < count_ff),
         .at_tail     (CNT_W'(i) == count_ff),
         .left_value  (left_value),
         .left_gt     (left_gt),
         .right_value (right_value),
         .value       (cell_value[i]),
         .gt          (cell_gt[i])
      );
   end

endmodule

@@ tb/sv/mhpq_checker.sv @@
module mhpq_checker
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      results_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the queue contents, kept as a binary max heap.
   logic signed [VALUE_W-1:0] heap_mem [CAPACITY];
   int unsigned               heap_fill;

   // Results still owed by the block, oldest first.
   rsp_type                   owed_results [$];

   // Applies one queue operation to the shadow heap and returns the result
   // the block must report for it.
   task automatic apply_queue_op(input req_type item, output rsp_type res);
      int unsigned               pos;
      int unsigned               parent;
      int unsigned               left_idx;
      int unsigned               right_idx;
      int unsigned               best;
      logic signed [VALUE_W-1:0] tmp;
      logic                      settled;
      res.status        = STATUS_DONE;
      res.removed_value = '0;
      if (item.operation == OP_INSERT) begin
         if (heap_fill >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            // Place at the next free slot and sift up while strictly greater.
            heap_mem[heap_fill] = item.value;
            pos                 = heap_fill;
            heap_fill++;
            settled = 1'b0;
            while (!settled && pos > 0) begin
               parent = (pos - 1) / 2;
               if (heap_mem[pos] > heap_mem[parent]) begin
                  tmp              = heap_mem[pos];
                  heap_mem[pos]    = heap_mem[parent];
                  heap_mem[parent] = tmp;
                  pos              = parent;
               end else begin
                  settled = 1'b1;
               end
            end
         end
      end else begin
         if (heap_fill == 0) begin
            res.status        = STATUS_EMPTY;
            res.removed_value = EMPTY_VALUE;
         end else begin
            // Take the root, move the last value up and sift it down.
            res.removed_value = heap_mem[0];
            heap_mem[0]       = heap_mem[heap_fill - 1];
            heap_fill--;
            pos     = 0;
            settled = 1'b0;
            while (!settled && pos < heap_fill) begin
               left_idx  = 2 * pos + 1;
               right_idx = 2 * pos + 2;
               best      = pos;
               if (left_idx < heap_fill && heap_mem[left_idx] > heap_mem[best]) begin
                  best = left_idx;
               end
               if (right_idx < heap_fill && heap_mem[right_idx] > heap_mem[best]) begin
                  best = right_idx;
               end
               if (best == pos) begin
                  settled = 1'b1;
               end else begin
                  tmp            = heap_mem[pos];
                  heap_mem[pos]  = heap_mem[best];
                  heap_mem[best] = tmp;
                  pos            = best;
               end
            end
         end
      end
      res.count = heap_fill[COUNT_W-1:0];
   endtask

   // Compare each result transfer with the oldest owed result, then predict
   // the result of any request transfer at the same edge.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      int      errs;
      errs = 0;
      if (reset) begin
         heap_fill = 0;
         owed_results.delete();
         mismatch_count      <= 0;
         results_outstanding <= 0;
      end else begin
         if (rsp_strobe) begin
            got = rsp_data;
            if (owed_results.size() == 0) begin
               $error("unexpected result: status %0d removed_value %0d count %0d",
                      got.status, got.removed_value, got.count);
               errs++;
            end else begin
               want = owed_results.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  errs++;
               end
               if (got.removed_value !== want.removed_value) begin
                  $error("removed_value: expected %0d, actual %0d",
                         want.removed_value, got.removed_value);
                  errs++;
               end
               if (got.count !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, got.count);
                  errs++;
               end
            end
         end
         if (start && !busy) begin
            apply_queue_op(req_data, want);
            owed_results.push_back(want);
         end
         mismatch_count      <= mismatch_count + errs;
         results_outstanding <= owed_results.size();
      end
   end

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mhpq_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 290;
   localparam int DRAIN_CYCLES = 1000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      mismatch_count;
   int      results_outstanding;
   int      cycle_count;

   max_heap_priority_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   mhpq_checker checker_inst (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_data            (req_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_data            (rsp_data),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // Presents one request and holds it until the block takes the transfer.
   task automatic send_item(input logic op, input logic signed [VALUE_W-1:0] val);
      req_type item;
      logic    taken;
      item.operation = op;
      item.value     = val;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
   endtask

   // Drops start for a number of cycles.
   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Holds off until every owed result has come back.
   task automatic wait_drained();
      int waited;
      waited = 0;
      idle_cycles(1);
      while (results_outstanding != 0 && waited < DRAIN_CYCLES) begin
         @(negedge clock);
         waited++;
      end
   endtask

   // Mix of fully random words, extremes and a narrow band that makes ties.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(9))
         0: v = 32'sh7fff_ffff;
         1: v = 32'sh8000_0000;
         2: v = $signed(32'($urandom_range(7)) - 32'd4);
         3: v = $signed(32'($urandom_range(3)) * 32'd1000);
         default: v = $signed($urandom);
      endcase
      return v;
   endfunction

   initial begin
      int insert_pct;
      int idle_pct;
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty removes, extremes, ties, then drain past empty.
      send_item(OP_REMOVE, 32'sd0);
      send_item(OP_REMOVE, 32'sh7fff_ffff);
      send_item(OP_INSERT, 32'sh7fff_ffff);
      send_item(OP_INSERT, 32'sh8000_0000);
      send_item(OP_INSERT, 32'sd0);
      send_item(OP_INSERT, -32'sd1);
      send_item(OP_INSERT, 32'sd5);
      send_item(OP_INSERT, 32'sd5);
      send_item(OP_INSERT, 32'sd5);
      send_item(OP_INSERT, -32'sd1);
      repeat (9) send_item(OP_REMOVE, $signed($urandom));
      send_item(OP_INSERT, 32'sh8000_0000);
      send_item(OP_REMOVE, 32'sh8000_0000);
      send_item(OP_INSERT, 32'sh8000_0000);
      send_item(OP_INSERT, 32'sh7fff_ffff);
      send_item(OP_REMOVE, -32'sd1);
      send_item(OP_REMOVE, 32'sd0);
      wait_drained();

      // Random phases 0 to 3 alternate between filling past capacity and draining
      // past empty; phases 4 and 5 mix both, and the last phase runs with no gaps.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0, 2: insert_pct = 85;
            1, 3: insert_pct = 15;
            4:    insert_pct = 60;
            default: insert_pct = 45;
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            idle_pct = (phase == 5 || (n / 40) % 2 == 1) ? 0 : 30;
            if ($urandom_range(99) < idle_pct) begin
               idle_cycles($urandom_range(1, 9));
            end
            if ($urandom_range(99) < insert_pct) begin
               send_item(OP_INSERT, pick_value());
            end else begin
               send_item(OP_REMOVE, $signed($urandom));
            end
         end
         if (phase == 1 || phase == 3) begin
            wait_drained();
         end
      end

      wait_drained();
      idle_cycles(10);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
